@@ hdl/dmrh_pkg.sv @@
// ----------------------------------------------------------------------------
// dmrh_pkg - shared types and constants of the double modulus rolling hash
// Hash base, the two prime moduli with their Barrett factors, the operation
// and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package dmrh_pkg;

  // Elements the store can hold and the widths that follow from it
  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
  localparam int unsigned LEN_W   = 13;

  // Residue width; both primes lie between 2^29 and 2^30
  localparam int unsigned MOD_W   = 30;
  localparam int unsigned PROD_W  = 2 * MOD_W;
  localparam int unsigned MU_W    = MOD_W + 1;
  localparam int unsigned RED_W   = MOD_W + 2;
  localparam int unsigned ELEM_W  = 8;

  localparam logic [MOD_W-1:0] HASH_BASE = MOD_W'(10007);
  localparam logic [MOD_W-1:0] MOD_LOW   = MOD_W'(1000000007);
  localparam logic [MOD_W-1:0] MOD_HIGH  = MOD_W'(1000000009);

  // Barrett factors floor(2^(2*MOD_W) / p), worked out at elaboration
  localparam logic [63:0] MU_LOW_WIDE  = (64'd1 << PROD_W) / 64'(MOD_LOW);
  localparam logic [63:0] MU_HIGH_WIDE = (64'd1 << PROD_W) / 64'(MOD_HIGH);
  localparam logic [MU_W-1:0] MU_LOW  = MU_LOW_WIDE[MU_W-1:0];
  localparam logic [MU_W-1:0] MU_HIGH = MU_HIGH_WIDE[MU_W-1:0];

  // Cycles from operands to registered residue in dmrh_modmul
  localparam int unsigned MUL_LAT = 4;
  localparam int unsigned CNT_W   = $clog2(MUL_LAT);

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_QUERY   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_e;

endpackage

@@ hdl/double_mod_rolling_hash.sv @@
// ----------------------------------------------------------------------------
// double_mod_rolling_hash - prefix hash store under two prime moduli
// Appends elements to a sequence of up to MAX_LEN bytes, keeping prefix
// hashes and base powers modulo 1e9+7 and 1e9+9 in two memories, and
// answers range hash queries from them.
//
//   channel  dir  tdata (low bit up)                    tuser
//   s_axis   in   element, range_start, range_end       opcode
//   m_axis   out  hash_low_prime, hash_high_prime,      status
//                 stored_length
//
// Every transaction is accepted and reads both memories, passes the Barrett
// multiply pipeline, then folds the result, writes back and loads the output
// register.
// The result sits in its own output register, so the next transaction is
// taken while it waits; the fold cycle holds only if that register is full.
// Reset clears the length; memory entries are used only after being written,
// so no clearing pass is run. The last prefix entry is kept in registers,
// so an append never uses data read from the memory it writes.
// ----------------------------------------------------------------------------
module double_mod_rolling_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // element[7:0], range_start[20:8], range_end[33:21]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // hash_low_prime[29:0], hash_high_prime[59:30],
                                     // stored_length[72:60]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned MW = dmrh_pkg::MOD_W;
  localparam int unsigned LW = dmrh_pkg::LEN_W;
  localparam int unsigned AW = dmrh_pkg::ADDR_W;

  dmrh_pkg::state_e state_q, state_d;
  logic [dmrh_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [LW-1:0]   len_q, len_d;
  logic [MW-1:0]   tail_hash_lo_q, tail_hash_lo_d;
  logic [MW-1:0]   tail_hash_hi_q, tail_hash_hi_d;
  logic [MW-1:0]   tail_pow_lo_q, tail_pow_lo_d;
  logic [MW-1:0]   tail_pow_hi_q, tail_pow_hi_d;
  logic            out_valid_q, out_valid_d;
  logic [79:0]     out_data_q, out_data_d;
  logic [1:0]      out_user_q, out_user_d;

  dmrh_pkg::op_e   op_q;
  logic [7:0]      elem_q;
  logic [LW-1:0]   start_q;
  logic [LW-1:0]   end_q;

  logic            in_acc;
  logic            fin_go;
  logic            mem_we;
  logic [LW-1:0]   in_start;
  logic [LW-1:0]   in_end;
  logic [AW-1:0]   rd_start_addr;
  logic [AW-1:0]   rd_end_addr;
  logic [AW-1:0]   rd_pow_addr;

  logic [2*MW-1:0] hash_mem [dmrh_pkg::MAX_LEN];
  logic [2*MW-1:0] pow_mem  [dmrh_pkg::MAX_LEN];
  logic [2*MW-1:0] hash_start_q;
  logic [2*MW-1:0] hash_end_q;
  logic [2*MW-1:0] pow_q;

  logic            start_zero, end_zero, span_zero;
  logic [MW-1:0]   h_start_lo, h_start_hi, h_end_lo, h_end_hi, pw_lo, pw_hi;
  logic [MW-1:0]   op_a_lo, op_a_hi, op_b_lo, op_b_hi;
  logic [7:0]      op_c;
  logic [MW-1:0]   res_hash_lo, res_hash_hi, res_pow_lo, res_pow_hi;
  logic [MW-1:0]   q_lo, q_hi;
  logic            range_ok;

  function automatic logic [MW-1:0] sub_mod(input logic [MW-1:0] x,
                                            input logic [MW-1:0] y,
                                            input logic [MW-1:0] m);
    logic [MW:0] diff;
    diff = (x >= y) ? {1'b0, x} - {1'b0, y} : {1'b0, x} + {1'b0, m} - {1'b0, y};
    return diff[MW-1:0];
  endfunction

  assign s_axis_tready = (state_q == dmrh_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fin_go        = !out_valid_q || m_axis_tready;

  // Entry k lives at address k-1; entry 0 is implicit
  assign in_start      = s_axis_tdata[20:8];
  assign in_end        = s_axis_tdata[33:21];
  assign rd_start_addr = AW'(in_start - LW'(1));
  assign rd_end_addr   = AW'(in_end - LW'(1));
  assign rd_pow_addr   = AW'(in_end - in_start - LW'(1));

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= dmrh_pkg::op_e'(s_axis_tuser);
      elem_q  <= s_axis_tdata[7:0];
      start_q <= in_start;
      end_q   <= in_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hash_mem[len_q[AW-1:0]] <= {res_hash_hi, res_hash_lo};
    end
    if (in_acc) begin
      hash_start_q <= hash_mem[rd_start_addr];
      hash_end_q   <= hash_mem[rd_end_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pow_mem[len_q[AW-1:0]] <= {res_pow_hi, res_pow_lo};
    end
    if (in_acc) begin
      pow_q <= pow_mem[rd_pow_addr];
    end
  end

  // Substitute the implicit entry 0 (hash 0, power 1)
  assign start_zero = (start_q == '0);
  assign end_zero   = (end_q == '0);
  assign span_zero  = (start_q == end_q);
  assign h_start_lo = start_zero ? '0 : hash_start_q[MW-1:0];
  assign h_start_hi = start_zero ? '0 : hash_start_q[2*MW-1:MW];
  assign h_end_lo   = end_zero ? '0 : hash_end_q[MW-1:0];
  assign h_end_hi   = end_zero ? '0 : hash_end_q[2*MW-1:MW];
  assign pw_lo      = span_zero ? MW'(1) : pow_q[MW-1:0];
  assign pw_hi      = span_zero ? MW'(1) : pow_q[2*MW-1:MW];

  always_comb begin
    if (op_q == dmrh_pkg::OP_APPEND) begin
      op_a_lo = tail_hash_lo_q;
      op_a_hi = tail_hash_hi_q;
      op_b_lo = dmrh_pkg::HASH_BASE;
      op_b_hi = dmrh_pkg::HASH_BASE;
      op_c    = elem_q;
    end else begin
      op_a_lo = h_start_lo;
      op_a_hi = h_start_hi;
      op_b_lo = pw_lo;
      op_b_hi = pw_hi;
      op_c    = '0;
    end
  end

  dmrh_modmul u_hash_lo (
    .clk_i      (clk_i),
    .high_mod_i (1'b0),
    .a_i        (op_a_lo),
    .b_i        (op_b_lo),
    .c_i        (op_c),
    .res_o      (res_hash_lo)
  );

  dmrh_modmul u_hash_hi (
    .clk_i      (clk_i),
    .high_mod_i (1'b1),
    .a_i        (op_a_hi),
    .b_i        (op_b_hi),
    .c_i        (op_c),
    .res_o      (res_hash_hi)
  );

  dmrh_modmul u_pow_lo (
    .clk_i      (clk_i),
    .high_mod_i (1'b0),
    .a_i        (tail_pow_lo_q),
    .b_i        (dmrh_pkg::HASH_BASE),
    .c_i        ('0),
    .res_o      (res_pow_lo)
  );

  dmrh_modmul u_pow_hi (
    .clk_i      (clk_i),
    .high_mod_i (1'b1),
    .a_i        (tail_pow_hi_q),
    .b_i        (dmrh_pkg::HASH_BASE),
    .c_i        ('0),
    .res_o      (res_pow_hi)
  );

  assign range_ok = (start_q <= end_q) && (end_q <= len_q);
  assign q_lo     = sub_mod(h_end_lo, res_hash_lo, dmrh_pkg::MOD_LOW);
  assign q_hi     = sub_mod(h_end_hi, res_hash_hi, dmrh_pkg::MOD_HIGH);

  always_comb begin
    logic [MW-1:0] hash_lo;
    logic [MW-1:0] hash_hi;
    dmrh_pkg::status_e status;

    state_d        = state_q;
    cnt_d          = cnt_q;
    len_d          = len_q;
    tail_hash_lo_d = tail_hash_lo_q;
    tail_hash_hi_d = tail_hash_hi_q;
    tail_pow_lo_d  = tail_pow_lo_q;
    tail_pow_hi_d  = tail_pow_hi_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_data_d     = out_data_q;
    out_user_d     = out_user_q;
    mem_we         = 1'b0;
    hash_lo        = '0;
    hash_hi        = '0;
    status         = dmrh_pkg::STAT_OK;

    unique case (state_q)
      dmrh_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = dmrh_pkg::ST_EXEC;
          cnt_d   = '0;
        end
      end
      dmrh_pkg::ST_EXEC: begin
        cnt_d = cnt_q + dmrh_pkg::CNT_W'(1);
        if (cnt_q == dmrh_pkg::CNT_W'(dmrh_pkg::MUL_LAT - 1)) begin
          state_d = dmrh_pkg::ST_FIN;
        end
      end
      dmrh_pkg::ST_FIN: begin
        if (fin_go) begin
          case (op_q)
            dmrh_pkg::OP_APPEND: begin
              if (len_q == LW'(dmrh_pkg::MAX_LEN)) begin
                status = dmrh_pkg::STAT_FULL;
              end else begin
                mem_we         = 1'b1;
                len_d          = len_q + LW'(1);
                tail_hash_lo_d = res_hash_lo;
                tail_hash_hi_d = res_hash_hi;
                tail_pow_lo_d  = res_pow_lo;
                tail_pow_hi_d  = res_pow_hi;
              end
            end
            dmrh_pkg::OP_QUERY: begin
              if (range_ok) begin
                hash_lo = q_lo;
                hash_hi = q_hi;
              end else begin
                status = dmrh_pkg::STAT_BAD_RANGE;
              end
            end
            dmrh_pkg::OP_RESTART: begin
              len_d          = '0;
              tail_hash_lo_d = '0;
              tail_hash_hi_d = '0;
              tail_pow_lo_d  = MW'(1);
              tail_pow_hi_d  = MW'(1);
            end
            default: begin
              // unused code: report the length, change nothing
            end
          endcase
          out_valid_d = 1'b1;
          out_data_d  = {7'd0, len_d, hash_hi, hash_lo};
          out_user_d  = status;
          state_d     = dmrh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dmrh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= dmrh_pkg::ST_IDLE;
      cnt_q          <= '0;
      len_q          <= '0;
      tail_hash_lo_q <= '0;
      tail_hash_hi_q <= '0;
      tail_pow_lo_q  <= MW'(1);
      tail_pow_hi_q  <= MW'(1);
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      len_q          <= len_d;
      tail_hash_lo_q <= tail_hash_lo_d;
      tail_hash_hi_q <= tail_hash_hi_d;
      tail_pow_lo_q  <= tail_pow_lo_d;
      tail_pow_hi_q  <= tail_pow_hi_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Length never passes the store capacity
  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(dmrh_pkg::MAX_LEN))
    else $error("stored length beyond capacity");

  // Write-back only from the fold cycle of an append with room left
  a_we_only_append : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == dmrh_pkg::ST_FIN) && (op_q == dmrh_pkg::OP_APPEND)
               && (len_q < LW'(dmrh_pkg::MAX_LEN)))
    else $error("memory write outside append fold");

  // A completed restart leaves an empty store
  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dmrh_pkg::ST_FIN && fin_go && op_q == dmrh_pkg::OP_RESTART)
    |=> (len_q == '0) && (tail_pow_lo_q == MW'(1)) && (tail_pow_hi_q == MW'(1)))
    else $error("restart did not clear the store");

  // Failed transactions carry zero hashes
  a_err_zero_hash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != dmrh_pkg::STAT_OK) |-> (m_axis_tdata[59:0] == '0))
    else $error("hash on a failed transaction");

endmodule

@@ hdl/dmrh_modmul.sv @@
// ----------------------------------------------------------------------------
// dmrh_modmul - pipelined modular multiply-add
// Computes (a * b + c) mod p for one of the two primes with a four stage
// Barrett reduction: product, quotient estimate, quotient times modulus,
// subtract and correct.
// ----------------------------------------------------------------------------
module dmrh_modmul (
  input  logic                        clk_i,
  input  logic                        high_mod_i, // 0: 1e9+7, 1: 1e9+9
  input  logic [dmrh_pkg::MOD_W-1:0]  a_i,
  input  logic [dmrh_pkg::MOD_W-1:0]  b_i,
  input  logic [dmrh_pkg::ELEM_W-1:0] c_i,
  output logic [dmrh_pkg::MOD_W-1:0]  res_o
);

  logic [dmrh_pkg::MOD_W-1:0]    p;
  logic [dmrh_pkg::MU_W-1:0]     mu;
  logic [dmrh_pkg::RED_W-1:0]    p1;
  logic [dmrh_pkg::RED_W-1:0]    p2;
  logic [dmrh_pkg::PROD_W-1:0]   prod_q;
  logic [2*dmrh_pkg::MU_W-1:0]   est_full;
  logic [dmrh_pkg::MU_W-1:0]     est_q;
  logic [dmrh_pkg::RED_W-1:0]    x1_q;
  logic [dmrh_pkg::RED_W-1:0]    x2_q;
  logic [dmrh_pkg::RED_W-1:0]    qp_q;
  logic [dmrh_pkg::RED_W-1:0]    rem;
  logic [dmrh_pkg::MOD_W-1:0]    res_d;
  logic [dmrh_pkg::MOD_W-1:0]    res_q;

  assign p  = high_mod_i ? dmrh_pkg::MOD_HIGH : dmrh_pkg::MOD_LOW;
  assign mu = high_mod_i ? dmrh_pkg::MU_HIGH : dmrh_pkg::MU_LOW;
  assign p1 = dmrh_pkg::RED_W'(p);
  assign p2 = dmrh_pkg::RED_W'(p) << 1;

  assign est_full = (2*dmrh_pkg::MU_W)'(prod_q[dmrh_pkg::PROD_W-1:dmrh_pkg::MOD_W-1])
                  * (2*dmrh_pkg::MU_W)'(mu);

  // Estimate is at most two short of the true quotient, so rem < 3p
  assign rem = x2_q - qp_q;

  always_comb begin
    if (rem >= p2) begin
      res_d = dmrh_pkg::MOD_W'(rem - p2);
    end else if (rem >= p1) begin
      res_d = dmrh_pkg::MOD_W'(rem - p1);
    end else begin
      res_d = dmrh_pkg::MOD_W'(rem);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= dmrh_pkg::PROD_W'(a_i) * dmrh_pkg::PROD_W'(b_i)
            + dmrh_pkg::PROD_W'(c_i);
    est_q  <= est_full[2*dmrh_pkg::MU_W-1:dmrh_pkg::MU_W];
    x1_q   <= prod_q[dmrh_pkg::RED_W-1:0];
    // only the low bits of q*p matter, the difference stays below 2^32
    qp_q   <= dmrh_pkg::RED_W'(est_q) * dmrh_pkg::RED_W'(p);
    x2_q   <= x1_q;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - stream-level check of double_mod_rolling_hash
// Feeds append, query, restart and unused-opcode transactions through the
// slave channel. A shadow copy of the prefix hash and base power tables
// gives the expected result of every accepted transaction, and each result
// on the master channel is checked field by field against the oldest one.
// The run covers a directed pass and random traffic under several patterns
// of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned     DEPTH        = 4096;
  localparam longint unsigned BASE         = 10007;
  localparam longint unsigned PRIME_LO     = 1000000007;
  localparam longint unsigned PRIME_HI     = 1000000009;
  localparam logic [1:0]      OP_UNUSED    = 2'd3;
  localparam int unsigned     CYCLE_LIMIT  = 1000000;
  localparam int unsigned     DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  element;
    logic [12:0] range_start;
    logic [12:0] range_end;
  } hash_cmd_t;

  typedef struct packed {
    logic [29:0] hash_lo;
    logic [29:0] hash_hi;
    logic [1:0]  status;
    logic [12:0] length;
  } hash_rsp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  double_mod_rolling_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow prefix hashes and base powers; entry 0 is hash 0, power 1
  longint unsigned pfx_lo [0:DEPTH];
  longint unsigned pfx_hi [0:DEPTH];
  longint unsigned pow_lo [0:DEPTH];
  longint unsigned pow_hi [0:DEPTH];
  int unsigned     seq_len = 0;

  hash_cmd_t   cmd_backlog [$];
  hash_rsp_t   awaited_results [$];
  hash_cmd_t   cur_cmd;
  hash_rsp_t   due;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned issued = 0, checked = 0, errors = 0, cycles = 0, gen_len = 0;
  int unsigned n_append = 0, n_full = 0, n_query_ok = 0, n_query_bad = 0;
  int unsigned n_restart = 0, n_unused = 0, peak_len = 0;

  function automatic hash_rsp_t compute_hash_result(hash_cmd_t cmd);
    hash_rsp_t       rsp;
    longint unsigned sub_lo, sub_hi;
    int unsigned     span;
    rsp = '0;
    rsp.status = dmrh_pkg::STAT_OK;
    case (cmd.opcode)
      dmrh_pkg::OP_APPEND: begin
        if (seq_len >= DEPTH) begin
          rsp.status = dmrh_pkg::STAT_FULL;
          n_full++;
        end else begin
          pfx_lo[seq_len+1] = (pfx_lo[seq_len] * BASE + cmd.element) % PRIME_LO;
          pfx_hi[seq_len+1] = (pfx_hi[seq_len] * BASE + cmd.element) % PRIME_HI;
          pow_lo[seq_len+1] = (pow_lo[seq_len] * BASE) % PRIME_LO;
          pow_hi[seq_len+1] = (pow_hi[seq_len] * BASE) % PRIME_HI;
          seq_len++;
          n_append++;
          if (seq_len > peak_len) peak_len = seq_len;
        end
      end
      dmrh_pkg::OP_QUERY: begin
        if (cmd.range_start <= cmd.range_end && cmd.range_end <= seq_len) begin
          span   = cmd.range_end - cmd.range_start;
          sub_lo = (pfx_lo[cmd.range_start] * pow_lo[span]) % PRIME_LO;
          sub_hi = (pfx_hi[cmd.range_start] * pow_hi[span]) % PRIME_HI;
          rsp.hash_lo = 30'((pfx_lo[cmd.range_end] + PRIME_LO - sub_lo) % PRIME_LO);
          rsp.hash_hi = 30'((pfx_hi[cmd.range_end] + PRIME_HI - sub_hi) % PRIME_HI);
          n_query_ok++;
        end else begin
          rsp.status = dmrh_pkg::STAT_BAD_RANGE;
          n_query_bad++;
        end
      end
      dmrh_pkg::OP_RESTART: begin
        seq_len = 0;
        n_restart++;
      end
      default: n_unused++;
    endcase
    rsp.length = 13'(seq_len);
    return rsp;
  endfunction

  task automatic check_field(string name, logic [29:0] want, logic [29:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Queue a transaction and follow the length it will leave behind
  task automatic add_cmd(logic [1:0] op, logic [7:0] el, logic [12:0] rs, logic [12:0] re);
    hash_cmd_t cmd;
    cmd = '{opcode: op, element: el, range_start: rs, range_end: re};
    cmd_backlog.push_back(cmd);
    issued++;
    if (op == dmrh_pkg::OP_APPEND && gen_len < DEPTH) gen_len++;
    else if (op == dmrh_pkg::OP_RESTART) gen_len = 0;
  endtask

  task automatic wait_drained();
    while (checked != issued) @(negedge clk_i);
  endtask

  // Mostly appends and in-range queries so the tables fill with real data
  task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct, int count);
    int unsigned pick, rs, re;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99, 0);
      rs   = $urandom_range(DEPTH, 0);
      re   = $urandom_range(DEPTH, 0);
      if (pick < 45) begin
        add_cmd(dmrh_pkg::OP_APPEND, 8'($urandom_range(255, 0)), 13'(rs), 13'(re));
      end else if (pick < 80) begin
        rs = $urandom_range(gen_len, 0);
        re = (pick < 74) ? $urandom_range(gen_len, rs) : gen_len;
        add_cmd(dmrh_pkg::OP_QUERY, 8'($urandom_range(255, 0)), 13'(rs), 13'(re));
      end else if (pick < 90) begin
        add_cmd(dmrh_pkg::OP_QUERY, 8'($urandom_range(255, 0)), 13'(rs), 13'(re));
      end else if (pick < 95) begin
        add_cmd(dmrh_pkg::OP_RESTART, 8'($urandom_range(255, 0)), 13'(rs), 13'(re));
      end else begin
        add_cmd(OP_UNUSED, 8'($urandom_range(255, 0)), 13'(rs), 13'(re));
      end
    end
    wait_drained();
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d of %0d results checked", $time, checked, issued);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Source: predict on acceptance, then present the next transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(compute_hash_result(cur_cmd));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          cur_cmd = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_cmd.opcode;
          s_axis_tdata  <= {6'b0, cur_cmd.range_end, cur_cmd.range_start, cur_cmd.element};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: random back-pressure, check every result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited: expected none, actual tdata %h tuser %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          due = awaited_results.pop_front();
          check_field("hash_low_prime", due.hash_lo, m_axis_tdata[29:0]);
          check_field("hash_high_prime", due.hash_hi, m_axis_tdata[59:30]);
          check_field("stored_length", 30'(due.length), 30'(m_axis_tdata[72:60]));
          check_field("status", 30'(due.status), 30'(m_axis_tuser));
          checked++;
        end
      end
    end
  end

  initial begin
    pfx_lo[0] = 0;
    pfx_hi[0] = 0;
    pow_lo[0] = 1;
    pow_hi[0] = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty store, extremes of the element, edges of the range check
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd0);
    add_cmd(dmrh_pkg::OP_QUERY, 8'hFF, 13'd0, 13'd1);
    add_cmd(OP_UNUSED, 8'hFF, 13'd4096, 13'd4095);
    add_cmd(dmrh_pkg::OP_APPEND, 8'h00, 13'd0, 13'd0);
    add_cmd(dmrh_pkg::OP_APPEND, 8'hFF, 13'd4096, 13'd4096);
    add_cmd(dmrh_pkg::OP_APPEND, 8'hA5, 13'd4095, 13'd0);
    add_cmd(dmrh_pkg::OP_APPEND, 8'h5A, 13'd0, 13'd4095);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd4);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd1, 13'd3);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd4, 13'd4);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd3, 13'd2);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd5);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd4096, 13'd4096);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd4096);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd4095, 13'd4095);
    add_cmd(dmrh_pkg::OP_RESTART, 8'hFF, 13'd4095, 13'd4095);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd1);
    add_cmd(dmrh_pkg::OP_APPEND, 8'hFF, 13'd0, 13'd0);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd0, 13'd1);
    add_cmd(dmrh_pkg::OP_QUERY, 8'h00, 13'd1, 13'd1);
    add_cmd(OP_UNUSED, 8'h00, 13'd0, 13'd0);
    wait_drained();

    run_random_phase(0, 0, 105);
    run_random_phase(48, 0, 105);
    run_random_phase(0, 48, 110);
    run_random_phase(12, 12, 110);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results: %0d appends, %0d appends on a full store, %0d good queries,",
             checked, n_append, n_full, n_query_ok);
    $display("%0d rejected queries, %0d restarts, %0d unused opcodes, longest sequence %0d",
             n_query_bad, n_restart, n_unused, peak_len);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
